// ===== hdl/mfl_pkg.sv =====
// shared constants, types and codes of the max-flow block
package mfl_pkg;

  localparam int NODE_W    = 10;
  localparam int NODES     = 1024;
  localparam int ARC_W     = 13;
  localparam int ARCS      = 8192;
  localparam int APTR_W    = 14;
  localparam int LVL_W     = 11;
  localparam int CAP_W     = 31;
  localparam int CNT_W     = 11;
  localparam int USED_W    = 14;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_D_W   = 11;

  localparam logic [APTR_W-1:0] ARC_NONE  = 14'h2000;
  localparam logic [LVL_W-1:0]  NO_LEVEL  = 11'h7FF;
  localparam logic [CAP_W-1:0]  CAP_MASK  = 31'h7FFF_FFFF;
  localparam logic [CAP_W-1:0]  TOTAL_MAX = 31'h7FFF_FFFF;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_OVF  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SINK       = 2'd2;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_LD_CHK, S_LD_A, S_LD_B, S_CMP, S_PI,
    S_B_POP, S_B_U, S_B_A, S_B_H, S_B_L, S_B_CHK,
    S_D_INIT, S_D_NODE, S_D_U, S_D_SCAN, S_D_H, S_D_L, S_D_P1, S_D_P2,
    S_A_M1, S_A_M2, S_A_U1, S_A_U2, S_A_U3, S_A_END, S_A_E2, S_FIN
  } state_t;

  typedef enum logic [5:0] {
    OP_NOP, OP_LOAD, OP_CLR, OP_LD_CHK, OP_LD_A, OP_LD_B, OP_CMP, OP_PI,
    OP_B_POP, OP_B_U, OP_B_A, OP_B_H, OP_B_L,
    OP_D_INIT, OP_D_NODE, OP_D_U, OP_D_SCAN, OP_D_H, OP_D_L, OP_D_P1, OP_D_P2,
    OP_A_M1, OP_A_M2, OP_A_U1, OP_A_U2, OP_A_U3, OP_A_END, OP_A_E2, OP_FIN
  } op_t;

  typedef struct packed {
    logic edge_ok;
    logic last;
    logic st_bad;
    logic st_same;
    logic cnt_end;
    logic clr_last;
    logic q_empty;
    logic first_none;
    logic next_none;
    logic t_reached;
    logic at_sink;
    logic cur_none;
    logic depth_zero;
    logic depth_full;
    logic scan_ok;
    logic more;
  } st_t;

endpackage

// ===== hdl/max_flow_level_graph.sv =====
// top level of the max-flow block: sequencer plus flow datapath
//
// edges are fed one word at a time with start while busy is low; a stored edge
// passes through accept, check and two list-head table updates, a dropped edge
// through accept and check only. the word with last_edge set starts the flow
// run, which repeats phases of level/pointer initialization, a breadth-first
// pass over scanned arcs and queued nodes, and a depth-first pass that scans
// arcs, enters nodes, retreats and augments along the path arcs; every step
// is one access on the arc and node memories. the single result word appears
// for exactly one cycle with out_valid and cannot be stalled, so the receiver
// must take it. after the result, and after reset, the list-head table is
// cleared with busy high.
// config writes are always taken; write them only while busy is low.
module max_flow_level_graph (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [mfl_pkg::NODE_W-1:0]          in_from_node,
  input  logic [mfl_pkg::NODE_W-1:0]          in_to_node,
  input  logic [mfl_pkg::CAP_W-1:0]           in_capacity,
  input  logic                                in_last_edge,
  output logic                                out_valid,
  output logic [mfl_pkg::CAP_W-1:0]           out_total_flow,
  output logic [mfl_pkg::STAT_W-1:0]          out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mfl_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mfl_pkg::CFG_D_W-1:0]         cfg_data
);

  mfl_pkg::op_t op;
  mfl_pkg::st_t st;

  // config registers accept a word every cycle
  assign cfg_ready = 1'b1;

  mfl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .st        (st),
    .op        (op),
    .busy      (busy),
    .out_valid (out_valid)
  );

  mfl_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .op             (op),
    .in_from_node   (in_from_node),
    .in_to_node     (in_to_node),
    .in_capacity    (in_capacity),
    .in_last_edge   (in_last_edge),
    .cfg_valid      (cfg_valid & cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .st             (st),
    .out_total_flow (out_total_flow),
    .out_status     (out_status)
  );

endmodule

// ===== hdl/mfl_ctrl.sv =====
// sequencer for edge loading, level labelling, blocking flow and table clearing
module mfl_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mfl_pkg::st_t  st,
  output mfl_pkg::op_t  op,
  output logic          busy,
  output logic          out_valid
);

  mfl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mfl_pkg::S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mfl_pkg::S_CLR:    if (st.clr_last) state_nxt = mfl_pkg::S_IDLE;
      mfl_pkg::S_IDLE:   if (start) state_nxt = mfl_pkg::S_LD_CHK;
      mfl_pkg::S_LD_CHK: begin
        if (st.edge_ok) state_nxt = mfl_pkg::S_LD_A;
        else if (st.last) state_nxt = mfl_pkg::S_CMP;
        else state_nxt = mfl_pkg::S_IDLE;
      end
      mfl_pkg::S_LD_A:   state_nxt = mfl_pkg::S_LD_B;
      mfl_pkg::S_LD_B:   state_nxt = st.last ? mfl_pkg::S_CMP : mfl_pkg::S_IDLE;
      mfl_pkg::S_CMP:    state_nxt = (st.st_bad || st.st_same) ? mfl_pkg::S_FIN
                                                               : mfl_pkg::S_PI;
      mfl_pkg::S_PI:     if (st.cnt_end) state_nxt = mfl_pkg::S_B_POP;
      mfl_pkg::S_B_POP:  state_nxt = st.q_empty ? mfl_pkg::S_B_CHK : mfl_pkg::S_B_U;
      mfl_pkg::S_B_U:    state_nxt = mfl_pkg::S_B_A;
      mfl_pkg::S_B_A:    state_nxt = st.first_none ? mfl_pkg::S_B_POP : mfl_pkg::S_B_H;
      mfl_pkg::S_B_H:    state_nxt = mfl_pkg::S_B_L;
      mfl_pkg::S_B_L:    state_nxt = st.next_none ? mfl_pkg::S_B_POP : mfl_pkg::S_B_H;
      mfl_pkg::S_B_CHK:  state_nxt = st.t_reached ? mfl_pkg::S_D_INIT : mfl_pkg::S_FIN;
      mfl_pkg::S_D_INIT: state_nxt = mfl_pkg::S_D_NODE;
      mfl_pkg::S_D_NODE: state_nxt = st.at_sink ? mfl_pkg::S_A_M1 : mfl_pkg::S_D_U;
      mfl_pkg::S_D_U:    state_nxt = mfl_pkg::S_D_SCAN;
      mfl_pkg::S_D_SCAN: begin
        if (!st.cur_none) state_nxt = mfl_pkg::S_D_H;
        else if (st.depth_zero) state_nxt = mfl_pkg::S_PI;
        else state_nxt = mfl_pkg::S_D_P1;
      end
      mfl_pkg::S_D_H:    state_nxt = mfl_pkg::S_D_L;
      mfl_pkg::S_D_L: begin
        if (!st.scan_ok) state_nxt = mfl_pkg::S_D_SCAN;
        else if (st.depth_full) state_nxt = mfl_pkg::S_PI;
        else state_nxt = mfl_pkg::S_D_NODE;
      end
      mfl_pkg::S_D_P1:   state_nxt = mfl_pkg::S_D_P2;
      mfl_pkg::S_D_P2:   state_nxt = mfl_pkg::S_D_NODE;
      mfl_pkg::S_A_M1:   state_nxt = mfl_pkg::S_A_M2;
      mfl_pkg::S_A_M2:   state_nxt = st.more ? mfl_pkg::S_A_M1 : mfl_pkg::S_A_U1;
      mfl_pkg::S_A_U1:   state_nxt = mfl_pkg::S_A_U2;
      mfl_pkg::S_A_U2:   state_nxt = mfl_pkg::S_A_U3;
      mfl_pkg::S_A_U3:   state_nxt = st.more ? mfl_pkg::S_A_U1 : mfl_pkg::S_A_END;
      mfl_pkg::S_A_END:  state_nxt = mfl_pkg::S_A_E2;
      mfl_pkg::S_A_E2:   state_nxt = mfl_pkg::S_D_NODE;
      mfl_pkg::S_FIN:    state_nxt = mfl_pkg::S_CLR;
      default:           state_nxt = mfl_pkg::S_CLR;
    endcase
  end

  always_comb begin
    busy      = (state_r != mfl_pkg::S_IDLE);
    out_valid = (state_r == mfl_pkg::S_FIN);
    case (state_r)
      mfl_pkg::S_CLR:    op = mfl_pkg::OP_CLR;
      mfl_pkg::S_IDLE:   op = start ? mfl_pkg::OP_LOAD : mfl_pkg::OP_NOP;
      mfl_pkg::S_LD_CHK: op = mfl_pkg::OP_LD_CHK;
      mfl_pkg::S_LD_A:   op = mfl_pkg::OP_LD_A;
      mfl_pkg::S_LD_B:   op = mfl_pkg::OP_LD_B;
      mfl_pkg::S_CMP:    op = mfl_pkg::OP_CMP;
      mfl_pkg::S_PI:     op = mfl_pkg::OP_PI;
      mfl_pkg::S_B_POP:  op = mfl_pkg::OP_B_POP;
      mfl_pkg::S_B_U:    op = mfl_pkg::OP_B_U;
      mfl_pkg::S_B_A:    op = mfl_pkg::OP_B_A;
      mfl_pkg::S_B_H:    op = mfl_pkg::OP_B_H;
      mfl_pkg::S_B_L:    op = mfl_pkg::OP_B_L;
      mfl_pkg::S_B_CHK:  op = mfl_pkg::OP_NOP;
      mfl_pkg::S_D_INIT: op = mfl_pkg::OP_D_INIT;
      mfl_pkg::S_D_NODE: op = mfl_pkg::OP_D_NODE;
      mfl_pkg::S_D_U:    op = mfl_pkg::OP_D_U;
      mfl_pkg::S_D_SCAN: op = mfl_pkg::OP_D_SCAN;
      mfl_pkg::S_D_H:    op = mfl_pkg::OP_D_H;
      mfl_pkg::S_D_L:    op = mfl_pkg::OP_D_L;
      mfl_pkg::S_D_P1:   op = mfl_pkg::OP_D_P1;
      mfl_pkg::S_D_P2:   op = mfl_pkg::OP_D_P2;
      mfl_pkg::S_A_M1:   op = mfl_pkg::OP_A_M1;
      mfl_pkg::S_A_M2:   op = mfl_pkg::OP_A_M2;
      mfl_pkg::S_A_U1:   op = mfl_pkg::OP_A_U1;
      mfl_pkg::S_A_U2:   op = mfl_pkg::OP_A_U2;
      mfl_pkg::S_A_U3:   op = mfl_pkg::OP_A_U3;
      mfl_pkg::S_A_END:  op = mfl_pkg::OP_A_END;
      mfl_pkg::S_A_E2:   op = mfl_pkg::OP_A_E2;
      mfl_pkg::S_FIN:    op = mfl_pkg::OP_FIN;
      default:           op = mfl_pkg::OP_NOP;
    endcase
  end

endmodule

// ===== hdl/mfl_dpath.sv =====
// arc and node memories, config registers and working registers of the flow engine
module mfl_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mfl_pkg::op_t                       op,
  input  logic [mfl_pkg::NODE_W-1:0]         in_from_node,
  input  logic [mfl_pkg::NODE_W-1:0]         in_to_node,
  input  logic [mfl_pkg::CAP_W-1:0]          in_capacity,
  input  logic                               in_last_edge,
  input  logic                               cfg_valid,
  input  logic [mfl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mfl_pkg::CFG_D_W-1:0]        cfg_data,
  output mfl_pkg::st_t                       st,
  output logic [mfl_pkg::CAP_W-1:0]          out_total_flow,
  output logic [mfl_pkg::STAT_W-1:0]         out_status
);

  localparam int NW = mfl_pkg::NODE_W;
  localparam int AW = mfl_pkg::ARC_W;
  localparam int PW = mfl_pkg::APTR_W;
  localparam int LW = mfl_pkg::LVL_W;
  localparam int CW = mfl_pkg::CAP_W;
  localparam int KW = mfl_pkg::CNT_W;
  localparam int UW = mfl_pkg::USED_W;

  // memories
  logic [PW-1:0] first_mem [mfl_pkg::NODES];
  logic [LW-1:0] level_mem [mfl_pkg::NODES];
  logic [PW-1:0] ptr_mem   [mfl_pkg::NODES];
  logic [NW-1:0] queue_mem [mfl_pkg::NODES];
  logic [AW-1:0] stack_mem [mfl_pkg::NODES];
  logic [NW-1:0] head_mem  [mfl_pkg::ARCS];
  logic [CW-1:0] res_mem   [mfl_pkg::ARCS];
  logic [PW-1:0] next_mem  [mfl_pkg::ARCS];

  logic          first_we, level_we, ptr_we, queue_we, stack_we, arc_we, res_we;
  logic [NW-1:0] first_wa, level_wa, ptr_wa, queue_wa, stack_wa;
  logic [NW-1:0] first_ra, level_ra, ptr_ra, queue_ra, stack_ra;
  logic [PW-1:0] first_wd, ptr_wd, next_wd;
  logic [LW-1:0] level_wd;
  logic [NW-1:0] queue_wd, head_wd;
  logic [AW-1:0] stack_wd, arc_wa, res_wa, head_ra, res_ra, next_ra;
  logic [CW-1:0] res_wd, arc_res_wd;

  logic [PW-1:0] first_rd_r, ptr_rd_r, next_rd_r;
  logic [LW-1:0] level_rd_r;
  logic [NW-1:0] queue_rd_r, head_rd_r;
  logic [AW-1:0] stack_rd_r;
  logic [CW-1:0] res_rd_r;

  // config and working registers
  logic [KW-1:0]        node_count_r, node_count_nxt;
  logic [NW-1:0]        source_r, source_nxt, sink_r, sink_nxt;
  logic [NW-1:0]        eu_r, eu_nxt, ev_r, ev_nxt;
  logic [CW-1:0]        ecap_r, ecap_nxt;
  logic                 elast_r, elast_nxt;
  logic [UW-1:0]        used_r, used_nxt;
  logic [1:0]           flags_r, flags_nxt;
  logic [CW-1:0]        total_r, total_nxt;
  logic [mfl_pkg::STAT_W-1:0] status_r, status_nxt;
  logic [KW-1:0]        cnt_r, cnt_nxt, qh_r, qh_nxt, qt_r, qt_nxt;
  logic [NW-1:0]        cur_u_r, cur_u_nxt, h_r, h_nxt;
  logic [LW-1:0]        lvl_u_r, lvl_u_nxt;
  logic [PW-1:0]        cur_a_r, cur_a_nxt, nx_r, nx_nxt;
  logic [CW-1:0]        r_r, r_nxt, b_r, b_nxt;
  logic [KW-1:0]        depth_r, depth_nxt, i_r, i_nxt, cut_r, cut_nxt;
  logic [AW-1:0]        cut_arc_r, cut_arc_nxt;

  logic [KW-1:0] n_use, i_inc, depth_dec;
  logic [LW-1:0] lvl_inc;
  logic [AW-1:0] arc_a, arc_b, cur_arc;
  logic [CW-1:0] res_dec;
  logic [CW:0]   total_sum;

  assign n_use     = (node_count_r > KW'(mfl_pkg::NODES)) ? KW'(mfl_pkg::NODES) : node_count_r;
  assign i_inc     = i_r + KW'(1);
  assign depth_dec = depth_r - KW'(1);
  assign lvl_inc   = lvl_u_r + LW'(1);
  assign arc_a     = used_r[AW-1:0];
  assign arc_b     = used_r[AW-1:0] | AW'(1);
  assign cur_arc   = cur_a_r[AW-1:0];
  assign res_dec   = res_rd_r - b_r;
  assign total_sum = {1'b0, total_r} + {1'b0, b_r};

  // status back to the sequencer
  always_comb begin
    st.edge_ok    = ({1'b0, eu_r} < n_use) && ({1'b0, ev_r} < n_use)
                    && (used_r <= UW'(mfl_pkg::ARCS - 2));
    st.last       = elast_r;
    st.st_bad     = ({1'b0, source_r} >= n_use) || ({1'b0, sink_r} >= n_use);
    st.st_same    = (source_r == sink_r);
    st.cnt_end    = (cnt_r == KW'(mfl_pkg::NODES));
    st.clr_last   = (cnt_r == KW'(mfl_pkg::NODES - 1));
    st.q_empty    = (qh_r == qt_r);
    st.first_none = first_rd_r[PW-1];
    st.next_none  = nx_r[PW-1];
    st.t_reached  = (level_rd_r != mfl_pkg::NO_LEVEL);
    st.at_sink    = (cur_u_r == sink_r);
    st.cur_none   = cur_a_r[PW-1];
    st.depth_zero = (depth_r == '0);
    st.depth_full = (depth_r >= KW'(mfl_pkg::NODES));
    st.scan_ok    = (level_rd_r != mfl_pkg::NO_LEVEL) && (level_rd_r == lvl_inc)
                    && (r_r != '0);
    st.more       = (i_inc < depth_r);
  end

  always_comb begin
    first_we = 1'b0; level_we = 1'b0; ptr_we = 1'b0; queue_we = 1'b0;
    stack_we = 1'b0; arc_we = 1'b0; res_we = 1'b0;
    first_wa = eu_r; first_wd = mfl_pkg::ARC_NONE; first_ra = eu_r;
    level_wa = cur_u_r; level_wd = mfl_pkg::NO_LEVEL; level_ra = cur_u_r;
    ptr_wa = cur_u_r; ptr_wd = cur_a_r; ptr_ra = cur_u_r;
    queue_wa = qt_r[NW-1:0]; queue_wd = h_r; queue_ra = qh_r[NW-1:0];
    stack_wa = depth_r[NW-1:0]; stack_wd = cur_arc; stack_ra = i_r[NW-1:0];
    arc_wa = arc_a; head_wd = ev_r; arc_res_wd = ecap_r; next_wd = first_rd_r;
    res_wa = cur_arc; res_wd = res_dec;
    head_ra = cur_arc; res_ra = cur_arc; next_ra = cur_arc;

    node_count_nxt = node_count_r; source_nxt = source_r; sink_nxt = sink_r;
    eu_nxt = eu_r; ev_nxt = ev_r; ecap_nxt = ecap_r; elast_nxt = elast_r;
    used_nxt = used_r; flags_nxt = flags_r; total_nxt = total_r; status_nxt = status_r;
    cnt_nxt = cnt_r; qh_nxt = qh_r; qt_nxt = qt_r; cur_u_nxt = cur_u_r; h_nxt = h_r;
    lvl_u_nxt = lvl_u_r; cur_a_nxt = cur_a_r; nx_nxt = nx_r; r_nxt = r_r; b_nxt = b_r;
    depth_nxt = depth_r; i_nxt = i_r; cut_nxt = cut_r; cut_arc_nxt = cut_arc_r;

    if (cfg_valid) begin
      case (cfg_index)
        mfl_pkg::REG_NODE_COUNT: node_count_nxt = cfg_data;
        mfl_pkg::REG_SOURCE:     source_nxt = cfg_data[NW-1:0];
        mfl_pkg::REG_SINK:       sink_nxt = cfg_data[NW-1:0];
        default: ;
      endcase
    end

    case (op)
      mfl_pkg::OP_LOAD: begin
        eu_nxt = in_from_node; ev_nxt = in_to_node;
        ecap_nxt = in_capacity & mfl_pkg::CAP_MASK; elast_nxt = in_last_edge;
      end
      mfl_pkg::OP_LD_CHK: begin
        // bad node drops the edge, otherwise a full table does
        if (!(({1'b0, eu_r} < n_use) && ({1'b0, ev_r} < n_use))) flags_nxt[1] = 1'b1;
        else if (used_r > UW'(mfl_pkg::ARCS - 2)) flags_nxt[0] = 1'b1;
      end
      mfl_pkg::OP_LD_A: begin
        arc_we = 1'b1;
        first_we = 1'b1; first_wd = {1'b0, arc_a};
        first_ra = ev_r;
      end
      mfl_pkg::OP_LD_B: begin
        // read of first[v] was issued beside the write of first[u]
        arc_we = 1'b1; arc_wa = arc_b; head_wd = eu_r; arc_res_wd = '0;
        next_wd = (eu_r == ev_r) ? {1'b0, arc_a} : first_rd_r;
        first_we = 1'b1; first_wa = ev_r; first_wd = {1'b0, arc_b};
        used_nxt = used_r + UW'(2);
      end
      mfl_pkg::OP_CMP: begin
        total_nxt = '0;
        cnt_nxt = '0;
        if (st.st_bad || flags_r[1]) status_nxt = mfl_pkg::STAT_BAD;
        else if (flags_r[0]) status_nxt = mfl_pkg::STAT_OVF;
        else status_nxt = mfl_pkg::STAT_OK;
      end
      mfl_pkg::OP_PI: begin
        // clear levels, copy list heads into arc pointers, then seed the queue with the source
        first_ra = cnt_r[NW-1:0];
        ptr_wa = NW'(cnt_r - KW'(1)); ptr_wd = first_rd_r;
        ptr_we = (cnt_r != '0);
        if (!st.cnt_end) begin
          level_we = 1'b1; level_wa = cnt_r[NW-1:0]; level_wd = mfl_pkg::NO_LEVEL;
          cnt_nxt = cnt_r + KW'(1);
        end else begin
          level_we = 1'b1; level_wa = source_r; level_wd = '0;
          queue_we = 1'b1; queue_wa = '0; queue_wd = source_r;
          qh_nxt = '0; qt_nxt = KW'(1);
        end
      end
      mfl_pkg::OP_B_POP: begin
        if (st.q_empty) level_ra = sink_r;
        else qh_nxt = qh_r + KW'(1);
      end
      mfl_pkg::OP_B_U: begin
        first_ra = queue_rd_r; level_ra = queue_rd_r;
      end
      mfl_pkg::OP_B_A: begin
        cur_a_nxt = first_rd_r; lvl_u_nxt = level_rd_r;
        head_ra = first_rd_r[AW-1:0]; res_ra = first_rd_r[AW-1:0];
        next_ra = first_rd_r[AW-1:0];
      end
      mfl_pkg::OP_B_H, mfl_pkg::OP_D_H: begin
        h_nxt = head_rd_r; r_nxt = res_rd_r; nx_nxt = next_rd_r;
        level_ra = head_rd_r;
      end
      mfl_pkg::OP_B_L: begin
        if ((level_rd_r == mfl_pkg::NO_LEVEL) && (r_r != '0)
            && (qt_r < KW'(mfl_pkg::NODES))) begin
          level_we = 1'b1; level_wa = h_r; level_wd = lvl_inc;
          queue_we = 1'b1;
          qt_nxt = qt_r + KW'(1);
        end
        head_ra = nx_r[AW-1:0]; res_ra = nx_r[AW-1:0]; next_ra = nx_r[AW-1:0];
      end
      mfl_pkg::OP_D_INIT: begin
        depth_nxt = '0; cur_u_nxt = source_r;
      end
      mfl_pkg::OP_D_NODE: begin
        if (st.at_sink) begin
          i_nxt = '0; b_nxt = mfl_pkg::CAP_MASK; stack_ra = '0;
        end
      end
      mfl_pkg::OP_D_U: begin
        lvl_u_nxt = level_rd_r; cur_a_nxt = ptr_rd_r;
      end
      mfl_pkg::OP_D_SCAN: begin
        if (st.cur_none) begin
          ptr_we = 1'b1;
          if (st.depth_zero) cnt_nxt = '0;
          else begin
            depth_nxt = depth_dec; stack_ra = depth_dec[NW-1:0];
          end
        end
      end
      mfl_pkg::OP_D_L: begin
        if (st.scan_ok) begin
          ptr_we = 1'b1;
          if (st.depth_full) cnt_nxt = '0;
          else begin
            stack_we = 1'b1;
            depth_nxt = depth_r + KW'(1); cur_u_nxt = h_r;
          end
        end else begin
          cur_a_nxt = nx_r;
        end
      end
      mfl_pkg::OP_D_P1: begin
        // tail of the popped arc is the head of its partner
        head_ra = stack_rd_r ^ AW'(1); next_ra = stack_rd_r;
      end
      mfl_pkg::OP_D_P2: begin
        ptr_we = 1'b1; ptr_wa = head_rd_r; ptr_wd = next_rd_r;
        cur_u_nxt = head_rd_r;
      end
      mfl_pkg::OP_A_M1: res_ra = stack_rd_r;
      mfl_pkg::OP_A_M2: begin
        if (res_rd_r < b_r) b_nxt = res_rd_r;
        if (st.more) begin
          i_nxt = i_inc; stack_ra = i_inc[NW-1:0];
        end else begin
          i_nxt = '0; cut_nxt = depth_r; stack_ra = '0;
        end
      end
      mfl_pkg::OP_A_U1: begin
        cur_a_nxt = {1'b0, stack_rd_r}; res_ra = stack_rd_r;
      end
      mfl_pkg::OP_A_U2: begin
        res_we = 1'b1;
        if ((cut_r == depth_r) && (res_dec == '0)) begin
          cut_nxt = i_r; cut_arc_nxt = cur_arc;
        end
        res_ra = cur_arc ^ AW'(1);
      end
      mfl_pkg::OP_A_U3: begin
        res_we = 1'b1; res_wa = cur_arc ^ AW'(1); res_wd = res_rd_r + b_r;
        if (st.more) begin
          i_nxt = i_inc; stack_ra = i_inc[NW-1:0];
        end
      end
      mfl_pkg::OP_A_END: begin
        total_nxt = total_sum[CW] ? mfl_pkg::TOTAL_MAX : total_sum[CW-1:0];
        depth_nxt = cut_r;
        head_ra = cut_arc_r ^ AW'(1);
      end
      mfl_pkg::OP_A_E2: cur_u_nxt = head_rd_r;
      mfl_pkg::OP_FIN:  cnt_nxt = '0;
      mfl_pkg::OP_CLR: begin
        first_we = 1'b1; first_wa = cnt_r[NW-1:0]; first_wd = mfl_pkg::ARC_NONE;
        cnt_nxt = cnt_r + KW'(1);
        if (st.clr_last) begin
          used_nxt = '0; flags_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (first_we) first_mem[first_wa] <= first_wd;
    first_rd_r <= first_mem[first_ra];
  end

  always_ff @(posedge clk) begin
    if (level_we) level_mem[level_wa] <= level_wd;
    level_rd_r <= level_mem[level_ra];
  end

  always_ff @(posedge clk) begin
    if (ptr_we) ptr_mem[ptr_wa] <= ptr_wd;
    ptr_rd_r <= ptr_mem[ptr_ra];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_wa] <= queue_wd;
    queue_rd_r <= queue_mem[queue_ra];
  end

  always_ff @(posedge clk) begin
    if (stack_we) stack_mem[stack_wa] <= stack_wd;
    stack_rd_r <= stack_mem[stack_ra];
  end

  always_ff @(posedge clk) begin
    if (arc_we) head_mem[arc_wa] <= head_wd;
    head_rd_r <= head_mem[head_ra];
  end

  always_ff @(posedge clk) begin
    if (arc_we) res_mem[arc_wa] <= arc_res_wd;
    else if (res_we) res_mem[res_wa] <= res_wd;
    res_rd_r <= res_mem[res_ra];
  end

  always_ff @(posedge clk) begin
    if (arc_we) next_mem[arc_wa] <= next_wd;
    next_rd_r <= next_mem[next_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= KW'(mfl_pkg::NODES);
      source_r     <= '0;
      sink_r       <= NW'(1);
      used_r       <= '0;
      flags_r      <= '0;
      cnt_r        <= '0;
    end else begin
      node_count_r <= node_count_nxt;
      source_r     <= source_nxt;
      sink_r       <= sink_nxt;
      used_r       <= used_nxt;
      flags_r      <= flags_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    eu_r <= eu_nxt; ev_r <= ev_nxt; ecap_r <= ecap_nxt; elast_r <= elast_nxt;
    total_r <= total_nxt; status_r <= status_nxt;
    qh_r <= qh_nxt; qt_r <= qt_nxt; cur_u_r <= cur_u_nxt; h_r <= h_nxt;
    lvl_u_r <= lvl_u_nxt; cur_a_r <= cur_a_nxt; nx_r <= nx_nxt; r_r <= r_nxt;
    b_r <= b_nxt; depth_r <= depth_nxt; i_r <= i_nxt; cut_r <= cut_nxt;
    cut_arc_r <= cut_arc_nxt;
  end

  assign out_total_flow = total_r;
  assign out_status     = status_r;

endmodule
